// ===== design/adaptive_replacement_cache_policy_macros.svh =====
// Assertion macros used by the cache policy module.
`ifndef ADAPTIVE_REPLACEMENT_CACHE_POLICY_MACROS_SVH
`define ADAPTIVE_REPLACEMENT_CACHE_POLICY_MACROS_SVH
// Implication checked on every clock edge outside reset.
`define ARC_ASSERT_IMP(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);
// Implication whose consequent is checked in the cycle after the antecedent.
`define ARC_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);
`endif

// ===== design/arc_pkg.sv =====
//------------------------------------------------------------------------------
// arc_pkg
// Types and constants shared by the cache policy modules.
//------------------------------------------------------------------------------
`default_nettype none
package arc_pkg;
   // List codes of a directory entry.
   typedef enum logic [1:0] {
      LIST_T1 = 2'd0,
      LIST_T2 = 2'd1,
      LIST_B1 = 2'd2,
      LIST_B2 = 2'd3
   } list_type;

   // Outcome codes of a result.
   localparam logic [2:0] OUT_MISS  = 3'd0;
   localparam logic [2:0] OUT_HIT_T1 = 3'd1;
   localparam logic [2:0] OUT_HIT_T2 = 3'd2;
   localparam logic [2:0] OUT_GHOST_B1 = 3'd3;
   localparam logic [2:0] OUT_GHOST_B2 = 3'd4;

   localparam int unsigned SIZE_W = 5;
   localparam logic [SIZE_W-1:0] SIZE_RESET = 5'd16;

   // Operation broadcast to every cell in the same cycle.
   typedef enum logic [2:0] {
      OP_NONE   = 3'd0,
      OP_SEARCH = 3'd1,
      OP_FIND   = 3'd2,
      OP_UNLINK = 3'd3,
      OP_LINK   = 3'd4,
      OP_FLUSH  = 3'd5,
      OP_FREE   = 3'd6
   } op_type;
endpackage
`default_nettype wire

// ===== design/arc_if.sv =====
//------------------------------------------------------------------------------
// arc_req_if / arc_rsp_if / arc_csr_if
// Valid/ready channels of the cache policy.
//------------------------------------------------------------------------------
`default_nettype none
interface arc_req_if;
   logic valid;
   logic ready;
   logic [31:0] page_key;
   modport source (output valid, output page_key, input ready);
   modport sink (input valid, input page_key, output ready);
endinterface

interface arc_rsp_if;
   logic valid;
   logic ready;
   logic [2:0] outcome;
   logic evicted_valid;
   logic [31:0] evicted_key;
   logic [4:0] target_t1_size;
   modport source (output valid, output outcome, output evicted_valid,
                   output evicted_key, output target_t1_size, input ready);
   modport sink (input valid, input outcome, input evicted_valid,
                 input evicted_key, input target_t1_size, output ready);
endinterface

interface arc_csr_if;
   logic valid;
   logic ready;
   logic [4:0] cache_size;
   modport source (output valid, output cache_size, input ready);
   modport sink (input valid, input cache_size, output ready);
endinterface
`default_nettype wire

// ===== design/arc_cell.sv =====
//------------------------------------------------------------------------------
// arc_cell
// One directory slot: key, list, rank and valid, with local match logic.
//------------------------------------------------------------------------------
`default_nettype none
module arc_cell #(
   parameter int KEY_WIDTH = 32,
   parameter int RANK_W = 5
) (
   input  wire logic clock,
   input  wire logic reset,
   input  wire arc_pkg::op_type op,
   input  wire logic [KEY_WIDTH-1:0] op_key,
   input  wire arc_pkg::list_type op_list,
   input  wire logic [RANK_W-1:0] op_rank,
   input  wire logic sel,
   input  wire logic free_in,
   output logic free_out,
   output logic hit,
   output logic [KEY_WIDTH-1:0] key_out,
   output arc_pkg::list_type list_out,
   output logic [RANK_W-1:0] rank_out
);
   import arc_pkg::*;

   logic [KEY_WIDTH-1:0] key_ff;
   list_type list_ff, list_in;
   logic [RANK_W-1:0] rank_ff, rank_in;
   logic valid_ff, valid_in;
   logic same_list;

   assign same_list = valid_ff && (list_ff == op_list);
   assign key_out = key_ff;
   assign list_out = list_ff;
   assign rank_out = rank_ff;
   // Free-slot priority chain passes along the row.
   assign free_out = free_in && valid_ff;

   // Match against the broadcast query.
   always_comb begin
      case (op)
         OP_SEARCH: hit = valid_ff && (key_ff == op_key);
         OP_FIND:   hit = same_list && (rank_ff == op_rank);
         OP_FREE:   hit = free_in && !valid_ff;
         default:   hit = 1'b0;
      endcase
   end

   // Next state of the slot.
   always_comb begin
      list_in = list_ff;
      rank_in = rank_ff;
      valid_in = valid_ff;
      case (op)
         OP_FLUSH: begin
            valid_in = 1'b0;
            list_in = LIST_T1;
            rank_in = '0;
         end
         OP_UNLINK: begin
            if (sel) valid_in = 1'b0;
            else if (same_list && rank_ff > op_rank) rank_in = rank_ff - 1'b1;
         end
         OP_LINK: begin
            if (sel) begin
               valid_in = 1'b1;
               list_in = op_list;
               rank_in = '0;
            end else if (same_list) rank_in = rank_ff + 1'b1;
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         list_ff <= LIST_T1;
         rank_ff <= '0;
      end else begin
         valid_ff <= valid_in;
         list_ff <= list_in;
         rank_ff <= rank_in;
      end
   end

   // Key store is written only when a new page takes the slot.
   always_ff @(posedge clock) begin
      if (op == OP_LINK && sel && op_list == LIST_T1) key_ff <= op_key;
   end
endmodule
`default_nettype wire

// ===== design/arc_divider.sv =====
//------------------------------------------------------------------------------
// arc_divider
// Restoring divider for ghost list lengths, one quotient bit per cycle.
//------------------------------------------------------------------------------
`default_nettype none
module arc_divider #(
   parameter int W = 9
) (
   input  wire logic clock,
   input  wire logic reset,
   input  wire logic start,
   input  wire logic [W-1:0] dividend,
   input  wire logic [W-1:0] divisor,
   output logic busy,
   output logic [W-1:0] quotient
);
   localparam int CW = $clog2(W + 1);
   logic [CW-1:0] cnt_ff;
   logic [W-1:0] rem_ff, quo_ff, div_ff;
   logic [W:0] trial;

   assign busy = (cnt_ff != '0);
   assign quotient = quo_ff;
   assign trial = {rem_ff, quo_ff[W-1]} - {1'b0, div_ff};

   // Shift in one dividend bit per cycle, subtract when it fits.
   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= '0;
      end else if (start) begin
         cnt_ff <= CW'(W);
         rem_ff <= '0;
         quo_ff <= dividend;
         div_ff <= divisor;
      end else if (busy) begin
         cnt_ff <= cnt_ff - 1'b1;
         if (!trial[W]) begin
            rem_ff <= trial[W-1:0];
            quo_ff <= {quo_ff[W-2:0], 1'b1};
         end else begin
            rem_ff <= {rem_ff[W-2:0], quo_ff[W-1]};
            quo_ff <= {quo_ff[W-2:0], 1'b0};
         end
      end
   end
endmodule
`default_nettype wire

// ===== design/adaptive_replacement_cache_policy.sv =====
//------------------------------------------------------------------------------
// adaptive_replacement_cache_policy
// ARC page replacement directory built as a row of slot cells.
//------------------------------------------------------------------------------
// Channel  Dir  Payload                                        Handshake
// req      in   page_key                                       req_valid/ready
// rsp      out  outcome, evicted_valid/key, target_t1_size     rsp_valid/ready
// csr      in   cache_size                                     csr_valid/ready
// One request at a time; the sequencer steps through its states issuing at
// most one broadcast cell operation per cycle, and a ghost hit also waits
// for the divider before the target is adapted.
// Reset (synchronous) empties all lists, clears p and sets cache_size to 16
// (CAPACITY if smaller). A finished result is held in the output register
// until taken; the next request is accepted once the result register is free.
//------------------------------------------------------------------------------
`default_nettype none
`include "adaptive_replacement_cache_policy_macros.svh"
module adaptive_replacement_cache_policy #(
   parameter int CAPACITY = 16,
   parameter int KEY_WIDTH = 32
) (
   input wire logic clock,
   input wire logic reset,
   arc_req_if.sink req,
   arc_rsp_if.source rsp,
   arc_csr_if.sink csr
);
   import arc_pkg::*;

   localparam int SLOTS = 2 * CAPACITY;
   localparam int RW = $clog2(SLOTS + 1);
   localparam int IW = $clog2(SLOTS);
   localparam int CW = RW + 1;

   typedef enum logic [4:0] {
      S_IDLE, S_SEARCH, S_DIV_WAIT, S_REP_PICK, S_REP_FIND, S_REP_UNLINK,
      S_REP_LINK, S_DROP_FIND, S_DROP_UNLINK, S_HIT_UNLINK, S_HIT_LINK,
      S_FREE, S_INS_LINK, S_MISS_DECIDE, S_DONE
   } state_type;

   state_type state_ff;
   op_type op;
   list_type op_list;
   logic [RW-1:0] op_rank;
   logic [KEY_WIDTH-1:0] key_ff;
   logic [SIZE_W-1:0] csize_ff, p_ff;
   logic [RW-1:0] cnt_ff [4];
   logic [IW-1:0] slot_ff, hit_slot_ff;
   logic hit_found_ff, in_b2_ff, rep_t1_ff, after_rep_ff;
   list_type drop_list_ff, hit_list_ff;
   logic [2:0] outcome_ff;
   logic ev_ff;
   logic [31:0] evk_ff;
   logic rsp_valid_ff;
   logic [SLOTS-1:0] cell_hit, cell_sel;
   logic [SLOTS:0] free_chain;
   logic [KEY_WIDTH-1:0] cell_key [SLOTS];
   list_type cell_list [SLOTS];
   logic [RW-1:0] cell_rank [SLOTS];
   logic any_hit;
   logic [IW-1:0] hit_idx;
   logic div_start, div_busy;
   logic [CW-1:0] div_q, div_n, div_d;
   logic [CW-1:0] l1, tot, csz;
   logic [SIZE_W:0] p_sum;
   logic [SIZE_W-1:0] d_sz;

   assign req.ready = (state_ff == S_IDLE) && !rsp_valid_ff && !csr.valid;
   assign csr.ready = (state_ff == S_IDLE) && !rsp_valid_ff;
   assign rsp.valid = rsp_valid_ff;
   assign rsp.outcome = outcome_ff;
   assign rsp.evicted_valid = ev_ff;
   assign rsp.evicted_key = ev_ff ? evk_ff : 32'd0;
   assign rsp.target_t1_size = p_ff;

   // Operation broadcast by the sequencer in each state.
   always_comb begin
      op = OP_NONE;
      op_list = LIST_T1;
      op_rank = '0;
      cell_sel = '0;
      case (state_ff)
         S_SEARCH: op = OP_SEARCH;
         S_REP_FIND: begin
            op = OP_FIND;
            op_list = rep_t1_ff ? LIST_T1 : LIST_T2;
            op_rank = cnt_ff[op_list] - 1'b1;
         end
         S_DROP_FIND: begin
            op = OP_FIND;
            op_list = drop_list_ff;
            op_rank = cnt_ff[op_list] - 1'b1;
         end
         S_REP_UNLINK, S_DROP_UNLINK: begin
            op = OP_UNLINK;
            op_list = cell_list[slot_ff];
            op_rank = cell_rank[slot_ff];
            cell_sel[slot_ff] = 1'b1;
         end
         S_REP_LINK: begin
            op = OP_LINK;
            op_list = rep_t1_ff ? LIST_B1 : LIST_B2;
            cell_sel[slot_ff] = 1'b1;
         end
         S_HIT_UNLINK: begin
            op = OP_UNLINK;
            op_list = hit_list_ff;
            op_rank = cell_rank[hit_slot_ff];
            cell_sel[hit_slot_ff] = 1'b1;
         end
         S_HIT_LINK: begin
            op = OP_LINK;
            op_list = LIST_T2;
            cell_sel[hit_slot_ff] = 1'b1;
         end
         S_FREE: op = OP_FREE;
         S_INS_LINK: begin
            op = OP_LINK;
            op_list = LIST_T1;
            cell_sel[slot_ff] = 1'b1;
         end
         default: ;
      endcase
      if (csr.valid && csr.ready) op = OP_FLUSH;
   end

   // Row of directory cells.
   assign free_chain[0] = 1'b1;
   for (genvar g = 0; g < SLOTS; g++) begin : g_cell
      arc_cell #(.KEY_WIDTH(KEY_WIDTH), .RANK_W(RW)) u_cell (
         .clock(clock), .reset(reset), .op(op), .op_key(key_ff),
         .op_list(op_list), .op_rank(op_rank), .sel(cell_sel[g]),
         .free_in(free_chain[g]), .free_out(free_chain[g+1]),
         .hit(cell_hit[g]), .key_out(cell_key[g]), .list_out(cell_list[g]),
         .rank_out(cell_rank[g])
      );
   end

   // Encode the single matching cell.
   always_comb begin
      hit_idx = '0;
      for (int i = 0; i < SLOTS; i++) if (cell_hit[i]) hit_idx = IW'(i);
   end
   assign any_hit = |cell_hit;

   // Ghost list ratio for the adaptation step.
   assign div_start = (state_ff == S_SEARCH) && any_hit &&
                      (cell_list[hit_idx] == LIST_B1 || cell_list[hit_idx] == LIST_B2);
   always_comb begin
      if (cell_list[hit_idx] == LIST_B1) begin
         div_n = CW'(cnt_ff[LIST_B2]);
         div_d = (cnt_ff[LIST_B1] != '0) ? CW'(cnt_ff[LIST_B1]) : CW'(1);
      end else begin
         div_n = CW'(cnt_ff[LIST_B1]);
         div_d = (cnt_ff[LIST_B2] != '0) ? CW'(cnt_ff[LIST_B2]) : CW'(1);
      end
   end
   arc_divider #(.W(CW)) u_div (
      .clock(clock), .reset(reset), .start(div_start), .dividend(div_n),
      .divisor(div_d), .busy(div_busy), .quotient(div_q)
   );

   assign l1 = CW'(cnt_ff[LIST_T1]) + CW'(cnt_ff[LIST_B1]);
   assign tot = l1 + CW'(cnt_ff[LIST_T2]) + CW'(cnt_ff[LIST_B2]);
   assign csz = CW'(csize_ff);
   assign d_sz = (div_q == '0) ? SIZE_W'(1) :
                 (div_q > CW'(csize_ff)) ? csize_ff : SIZE_W'(div_q);
   assign p_sum = {1'b0, p_ff} + {1'b0, d_sz};

   // Sequencer, counters and result register.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         csize_ff <= (CAPACITY < 16) ? SIZE_W'(CAPACITY) : SIZE_RESET;
         p_ff <= '0;
         for (int k = 0; k < 4; k++) cnt_ff[k] <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (rsp_valid_ff && rsp.ready) rsp_valid_ff <= 1'b0;
         case (state_ff)
            S_IDLE: begin
               if (csr.valid && csr.ready) begin
                  csize_ff <= (csr.cache_size == '0) ? SIZE_W'(1) :
                     (32'(csr.cache_size) > CAPACITY) ? SIZE_W'(CAPACITY) : csr.cache_size;
                  p_ff <= '0;
                  for (int k = 0; k < 4; k++) cnt_ff[k] <= '0;
               end else if (req.valid && req.ready) begin
                  key_ff <= KEY_WIDTH'(req.page_key);
                  ev_ff <= 1'b0;
                  evk_ff <= '0;
                  state_ff <= S_SEARCH;
               end
            end
            S_SEARCH: begin
               hit_found_ff <= any_hit;
               hit_slot_ff <= hit_idx;
               hit_list_ff <= cell_list[hit_idx];
               after_rep_ff <= 1'b0;
               if (!any_hit) begin
                  outcome_ff <= OUT_MISS;
                  state_ff <= S_MISS_DECIDE;
               end else begin
                  case (cell_list[hit_idx])
                     LIST_T1: outcome_ff <= OUT_HIT_T1;
                     LIST_T2: outcome_ff <= OUT_HIT_T2;
                     LIST_B1: outcome_ff <= OUT_GHOST_B1;
                     default: outcome_ff <= OUT_GHOST_B2;
                  endcase
                  in_b2_ff <= (cell_list[hit_idx] == LIST_B2);
                  state_ff <= div_start ? S_DIV_WAIT : S_HIT_UNLINK;
               end
            end
            S_DIV_WAIT: begin
               if (!div_busy) begin
                  if (!in_b2_ff)
                     p_ff <= (p_sum > {1'b0, csize_ff}) ? csize_ff : p_sum[SIZE_W-1:0];
                  else
                     p_ff <= (p_ff > d_sz) ? p_ff - d_sz : '0;
                  state_ff <= S_REP_PICK;
               end
            end
            S_MISS_DECIDE: begin
               in_b2_ff <= 1'b0;
               if (l1 == csz) begin
                  if (CW'(cnt_ff[LIST_T1]) < csz) begin
                     drop_list_ff <= LIST_B1;
                     after_rep_ff <= 1'b1;
                  end else begin
                     drop_list_ff <= LIST_T1;
                  end
                  state_ff <= S_DROP_FIND;
               end else if (l1 < csz && tot >= csz) begin
                  if (tot == {csz[CW-2:0], 1'b0}) begin
                     drop_list_ff <= LIST_B2;
                     after_rep_ff <= 1'b1;
                     state_ff <= S_DROP_FIND;
                  end else state_ff <= S_REP_PICK;
               end else state_ff <= S_FREE;
            end
            S_DROP_FIND: begin
               slot_ff <= hit_idx;
               if (any_hit && cnt_ff[drop_list_ff] != '0) begin
                  if (drop_list_ff == LIST_T1) begin
                     ev_ff <= 1'b1;
                     evk_ff <= 32'(cell_key[hit_idx]);
                  end
                  state_ff <= S_DROP_UNLINK;
               end else state_ff <= after_rep_ff ? S_REP_PICK : S_FREE;
            end
            S_DROP_UNLINK: begin
               cnt_ff[drop_list_ff] <= cnt_ff[drop_list_ff] - 1'b1;
               state_ff <= after_rep_ff ? S_REP_PICK : S_FREE;
            end
            S_REP_PICK: begin
               logic ft1;
               logic [RW-1:0] t1;
               t1 = cnt_ff[LIST_T1];
               ft1 = (t1 != '0) && ((in_b2_ff && CW'(t1) == CW'(p_ff)) ||
                     CW'(t1) > CW'(p_ff));
               if (!ft1 && cnt_ff[LIST_T2] == '0) ft1 = (t1 != '0);
               rep_t1_ff <= ft1;
               if (!ft1 && cnt_ff[LIST_T2] == '0)
                  state_ff <= hit_found_ff ? S_HIT_UNLINK : S_FREE;
               else state_ff <= S_REP_FIND;
            end
            S_REP_FIND: begin
               slot_ff <= hit_idx;
               if (any_hit) begin
                  ev_ff <= 1'b1;
                  evk_ff <= 32'(cell_key[hit_idx]);
                  state_ff <= S_REP_UNLINK;
               end else state_ff <= hit_found_ff ? S_HIT_UNLINK : S_FREE;
            end
            S_REP_UNLINK: begin
               if (rep_t1_ff) cnt_ff[LIST_T1] <= cnt_ff[LIST_T1] - 1'b1;
               else cnt_ff[LIST_T2] <= cnt_ff[LIST_T2] - 1'b1;
               state_ff <= S_REP_LINK;
            end
            S_REP_LINK: begin
               if (rep_t1_ff) cnt_ff[LIST_B1] <= cnt_ff[LIST_B1] + 1'b1;
               else cnt_ff[LIST_B2] <= cnt_ff[LIST_B2] + 1'b1;
               state_ff <= hit_found_ff ? S_HIT_UNLINK : S_FREE;
            end
            S_HIT_UNLINK: begin
               cnt_ff[hit_list_ff] <= cnt_ff[hit_list_ff] - 1'b1;
               state_ff <= S_HIT_LINK;
            end
            S_HIT_LINK: begin
               cnt_ff[LIST_T2] <= cnt_ff[LIST_T2] + 1'b1;
               state_ff <= S_DONE;
            end
            S_FREE: begin
               slot_ff <= hit_idx;
               state_ff <= any_hit ? S_INS_LINK : S_DONE;
            end
            S_INS_LINK: begin
               cnt_ff[LIST_T1] <= cnt_ff[LIST_T1] + 1'b1;
               state_ff <= S_DONE;
            end
            S_DONE: begin
               rsp_valid_ff <= 1'b1;
               state_ff <= S_IDLE;
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

   // Checks on the sequencer and directory.
   `ARC_ASSERT_IMP(a_one_match, clock, reset, op == OP_SEARCH, $onehot0(cell_hit), "two cells match one key")
   `ARC_ASSERT_IMP(a_p_bound, clock, reset, 1'b1, p_ff <= csize_ff, "target above cache size")
   `ARC_ASSERT_NEXT(a_done_rsp, clock, reset, state_ff == S_DONE, rsp_valid_ff, "result not posted")
   `ARC_ASSERT_IMP(a_no_accept_busy, clock, reset, rsp_valid_ff, !req.ready, "request taken over held result")
endmodule
`default_nettype wire

// ===== sim/tb_top.sv =====
//------------------------------------------------------------------------------
// tb_top
// Self-checking bench for the ARC replacement policy. A behavioral model of
// the four recency lists and the adaptive target predicts every result; the
// bench drives page requests over valid/ready with random stalls on both
// sides and rewrites the cache size between phases.
//------------------------------------------------------------------------------
`default_nettype none
module tb_top;
   import arc_pkg::*;

   localparam int CAP = 16;
   localparam int SLOTS = 2 * CAP;

   typedef struct packed {
      logic [2:0] outcome;
      logic ev_valid;
      logic [31:0] ev_key;
      logic [4:0] target;
   } arc_result_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   arc_req_if req_ch();
   arc_rsp_if rsp_ch();
   arc_csr_if csr_ch();

   adaptive_replacement_cache_policy #(.CAPACITY(CAP), .KEY_WIDTH(32)) i_dut (
      .clock(clock),
      .reset(reset),
      .req(req_ch.sink),
      .rsp(rsp_ch.source),
      .csr(csr_ch.sink)
   );

   always #5 clock = ~clock;

   // Shadow copy of the directory.
   logic [31:0] dir_key [SLOTS];
   list_type dir_list [SLOTS];
   bit dir_valid [SLOTS];
   int unsigned dir_rank [SLOTS];
   int unsigned list_len [4];
   int unsigned adapt_p;
   int unsigned size_c;

   arc_result_type expected_q [$];
   int error_count = 0;
   int send_idle_pct = 0;
   int recv_idle_pct = 0;
   logic [31:0] recent_keys [$];

   // Empty every list and clear the target.
   function automatic void flush_shadow();
      for (int i = 0; i < SLOTS; i++) begin
         dir_valid[i] = 0;
         dir_rank[i] = 0;
         dir_list[i] = LIST_T1;
      end
      for (int i = 0; i < 4; i++) list_len[i] = 0;
      adapt_p = 0;
   endfunction

   function automatic void unlink_entry(int e);
      list_type l;
      l = dir_list[e];
      for (int i = 0; i < SLOTS; i++)
         if (i != e && dir_valid[i] && dir_list[i] == l && dir_rank[i] > dir_rank[e])
            dir_rank[i]--;
      if (list_len[l] > 0) list_len[l]--;
      dir_valid[e] = 0;
   endfunction

   function automatic void link_front(int e, list_type l);
      for (int i = 0; i < SLOTS; i++)
         if (i != e && dir_valid[i] && dir_list[i] == l) dir_rank[i]++;
      dir_list[e] = l;
      dir_rank[e] = 0;
      dir_valid[e] = 1;
      list_len[l]++;
   endfunction

   function automatic int lru_of(list_type l);
      if (list_len[l] == 0) return -1;
      for (int i = 0; i < SLOTS; i++)
         if (dir_valid[i] && dir_list[i] == l && dir_rank[i] == list_len[l] - 1) return i;
      return -1;
   endfunction

   function automatic void drop_tail(list_type l, ref bit ev, ref logic [31:0] evk);
      int e;
      e = lru_of(l);
      if (e < 0) return;
      if (l == LIST_T1 || l == LIST_T2) begin
         ev = 1;
         evk = dir_key[e];
      end
      unlink_entry(e);
   endfunction

   // The ARC REPLACE rule: demote one resident page to its ghost list.
   function automatic void demote_page(bit in_b2, ref bit ev, ref logic [31:0] evk);
      int unsigned t1;
      bit from_t1;
      int e;
      t1 = list_len[LIST_T1];
      from_t1 = (t1 >= 1) && ((in_b2 && t1 == adapt_p) || t1 > adapt_p);
      if (!from_t1 && list_len[LIST_T2] == 0) from_t1 = (t1 >= 1);
      if (!from_t1 && list_len[LIST_T2] == 0) return;
      e = lru_of(from_t1 ? LIST_T1 : LIST_T2);
      if (e < 0) return;
      ev = 1;
      evk = dir_key[e];
      unlink_entry(e);
      link_front(e, from_t1 ? LIST_B1 : LIST_B2);
   endfunction

   // Work out the result of one page request and update the shadow state.
   function automatic arc_result_type predict_access(logic [31:0] key);
      arc_result_type r;
      bit ev;
      logic [31:0] evk;
      int hit;
      int slot;
      int unsigned d;
      int unsigned l1;
      int unsigned tot;
      ev = 0;
      evk = '0;
      hit = -1;
      slot = -1;
      r.outcome = OUT_MISS;
      for (int i = 0; i < SLOTS; i++)
         if (hit < 0 && dir_valid[i] && dir_key[i] == key) hit = i;
      if (hit >= 0) begin
         case (dir_list[hit])
            LIST_T1: r.outcome = OUT_HIT_T1;
            LIST_T2: r.outcome = OUT_HIT_T2;
            LIST_B1: begin
               r.outcome = OUT_GHOST_B1;
               d = list_len[LIST_B2] / (list_len[LIST_B1] ? list_len[LIST_B1] : 1);
               if (d < 1) d = 1;
               adapt_p = (adapt_p + d > size_c) ? size_c : adapt_p + d;
               demote_page(0, ev, evk);
            end
            default: begin
               r.outcome = OUT_GHOST_B2;
               d = list_len[LIST_B1] / (list_len[LIST_B2] ? list_len[LIST_B2] : 1);
               if (d < 1) d = 1;
               adapt_p = (adapt_p > d) ? adapt_p - d : 0;
               demote_page(1, ev, evk);
            end
         endcase
         unlink_entry(hit);
         link_front(hit, LIST_T2);
      end else begin
         l1 = list_len[LIST_T1] + list_len[LIST_B1];
         tot = l1 + list_len[LIST_T2] + list_len[LIST_B2];
         if (l1 == size_c) begin
            if (list_len[LIST_T1] < size_c) begin
               drop_tail(LIST_B1, ev, evk);
               demote_page(0, ev, evk);
            end else begin
               drop_tail(LIST_T1, ev, evk);
            end
         end else if (l1 < size_c && tot >= size_c) begin
            if (tot == 2 * size_c) drop_tail(LIST_B2, ev, evk);
            demote_page(0, ev, evk);
         end
         for (int i = 0; i < SLOTS; i++)
            if (slot < 0 && !dir_valid[i]) slot = i;
         if (slot >= 0) begin
            dir_key[slot] = key;
            link_front(slot, LIST_T1);
         end
      end
      r.ev_valid = ev;
      r.ev_key = ev ? evk : '0;
      r.target = adapt_p[4:0];
      return r;
   endfunction

   // Send one page request and queue its expected result. Valid stays high
   // after acceptance only until the next falling edge, where the next call
   // either presents a new request or drops it.
   task automatic send_request(logic [31:0] key);
      while ($urandom_range(99) < send_idle_pct) begin
         req_ch.valid <= 1'b0;
         @(negedge clock);
      end
      req_ch.valid <= 1'b1;
      req_ch.page_key <= key;
      @(posedge clock);
      while (!req_ch.ready) @(posedge clock);
      expected_q.push_back(predict_access(key));
      recent_keys.push_back(key);
      if (recent_keys.size() > 48) void'(recent_keys.pop_front());
      @(negedge clock);
   endtask

   // Wait until every expected result has come, then let the block settle.
   task automatic drain();
      int guard;
      guard = 0;
      req_ch.valid <= 1'b0;
      while (expected_q.size() != 0 && guard < 200000) begin
         @(negedge clock);
         guard++;
      end
      repeat (40) @(negedge clock);
   endtask

   // Write the cache size while the block is idle.
   task automatic write_size(logic [4:0] value);
      drain();
      csr_ch.valid <= 1'b1;
      csr_ch.cache_size <= value;
      @(posedge clock);
      while (!csr_ch.ready) @(posedge clock);
      size_c = (value == 0) ? 1 : (value > CAP) ? CAP : value;
      flush_shadow();
      recent_keys.delete();
      @(negedge clock);
      csr_ch.valid <= 1'b0;
   endtask

   // Key choice: mostly a small working set so that hits and ghost hits occur.
   function automatic logic [31:0] pick_key(int unsigned pool);
      int unsigned sel;
      sel = $urandom_range(99);
      if (sel < 50 && recent_keys.size() > 0)
         return recent_keys[$urandom_range(recent_keys.size() - 1)];
      if (sel < 90) return 32'h0000_1000 + $urandom_range(pool - 1);
      return $urandom();
   endfunction

   // Key extremes and the hit, ghost and miss paths with a tiny cache.
   task automatic test_directed();
      write_size(5'd2);
      send_request(32'h0000_0000);
      send_request(32'hFFFF_FFFF);
      send_request(32'h0000_0000);
      send_request(32'h0000_0000);
      send_request(32'hAAAA_AAAA);
      send_request(32'h5555_5555);
      send_request(32'hFFFF_FFFF);
      send_request(32'h0000_0000);
      send_request(32'hAAAA_AAAA);
      send_request(32'h1234_5678);
      send_request(32'h5555_5555);
      send_request(32'h0000_0001);
      write_size(5'd1);
      send_request(32'h8000_0000);
      send_request(32'h0000_0001);
      send_request(32'h8000_0000);
      send_request(32'h8000_0000);
      send_request(32'h0000_0001);
      // Out-of-range sizes are clamped.
      write_size(5'd0);
      send_request(32'h7FFF_FFFF);
      send_request(32'h7FFF_FFFF);
      write_size(5'd31);
      send_request(32'h0F0F_0F0F);
   endtask

   // Random requests at a given cache size and idling mix.
   task automatic test_random(int count, logic [4:0] size, int s_idle, int r_idle);
      write_size(size);
      send_idle_pct = s_idle;
      recv_idle_pct = r_idle;
      for (int i = 0; i < count; i++) begin
         send_request(pick_key(3 * ((size == 0 || size > CAP) ? CAP : size) + 2));
         if (i == count / 2) drain();
      end
   endtask

   // Result checker.
   always @(posedge clock) begin
      arc_result_type exp_r;
      if (!reset && rsp_ch.valid && rsp_ch.ready) begin
         if (expected_q.size() == 0) begin
            error_count++;
            if (error_count <= 10) $display("Unexpected result transaction");
         end else begin
            exp_r = expected_q.pop_front();
            if (rsp_ch.outcome !== exp_r.outcome || rsp_ch.evicted_valid !== exp_r.ev_valid
                || rsp_ch.evicted_key !== exp_r.ev_key
                || rsp_ch.target_t1_size !== exp_r.target) begin
               error_count++;
               if (error_count <= 10)
                  $display("Mismatch: expected %0d/%0b/%h/%0d got %0d/%0b/%h/%0d",
                           exp_r.outcome, exp_r.ev_valid, exp_r.ev_key, exp_r.target,
                           rsp_ch.outcome, rsp_ch.evicted_valid, rsp_ch.evicted_key,
                           rsp_ch.target_t1_size);
            end
         end
      end
   end

   // Receiver stalls.
   always @(negedge clock) begin
      rsp_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
   end

   initial begin
      req_ch.valid = 1'b0;
      req_ch.page_key = '0;
      csr_ch.valid = 1'b0;
      csr_ch.cache_size = '0;
      rsp_ch.ready = 1'b0;
      size_c = CAP;
      flush_shadow();
      repeat (11) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      // Traffic at the reset size first.
      send_request(32'h0000_0042);
      send_request(32'h0000_0042);
      test_directed();
      test_random(200, 5'd16, 28, 59);
      test_random(200, 5'd3, 28, 59);
      test_random(200, 5'd1, 59, 28);
      test_random(200, 5'd8, 59, 28);
      test_random(225, 5'd16, 0, 0);
      test_random(200, 5'd5, 0, 0);
      drain();
      if (error_count == 0 && expected_q.size() == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("DONE: errors detected");
      end
      $finish;
   end

   // Watchdog.
   initial begin
      #5000000;
      $display("DONE: errors detected");
      $finish;
   end
endmodule
`default_nettype wire
